### rtl/rpfp_pkg.sv
// rpfp_pkg: shared types and constants of the rtcp packet field parser
// no dependencies; used by the interfaces and by every rtl module

package rpfp_pkg;

    // field widths of the channels
    localparam int BYTE_W   = 8;
    localparam int ID_W     = 5;
    localparam int VALUE_W  = 32;
    localparam int BLOCK_W  = 5;
    localparam int STATUS_W = 2;

    // field identifiers
    localparam logic [ID_W-1:0] ID_VERSION  = 5'd0;
    localparam logic [ID_W-1:0] ID_PADDING  = 5'd1;
    localparam logic [ID_W-1:0] ID_COUNT    = 5'd2;
    localparam logic [ID_W-1:0] ID_TYPE     = 5'd3;
    localparam logic [ID_W-1:0] ID_LENGTH   = 5'd4;
    localparam logic [ID_W-1:0] ID_SSRC     = 5'd5;
    localparam logic [ID_W-1:0] ID_SRC_SSRC = 5'd11;
    localparam logic [ID_W-1:0] ID_FRAC     = 5'd12;
    localparam logic [ID_W-1:0] ID_CUM_LOST = 5'd13;
    localparam logic [ID_W-1:0] ID_EXT_SEQ  = 5'd14;
    localparam logic [ID_W-1:0] ID_JITTER   = 5'd15;
    localparam logic [ID_W-1:0] ID_LSR      = 5'd16;
    localparam logic [ID_W-1:0] ID_DLSR     = 5'd17;
    localparam logic [ID_W-1:0] ID_STATUS   = 5'd18;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd3;

    // parse phases
    localparam int PH_W = 2;
    localparam logic [PH_W-1:0] PH_HEADER = 2'd0;
    localparam logic [PH_W-1:0] PH_INFO   = 2'd1;
    localparam logic [PH_W-1:0] PH_BLOCK  = 2'd2;
    localparam logic [PH_W-1:0] PH_SKIP   = 2'd3;

    // packet types
    localparam logic [BYTE_W-1:0] KIND_SR   = 8'd200;
    localparam logic [BYTE_W-1:0] KIND_RR   = 8'd201;
    localparam logic [BYTE_W-1:0] KIND_SDES = 8'd202;
    localparam logic [BYTE_W-1:0] KIND_APP  = 8'd204;

    // layout sizes in bytes
    localparam int POS_W = 5;
    localparam logic [POS_W:0] BLOCK_BYTES   = 6'd24;
    localparam logic [POS_W:0] SR_INFO_BYTES = 6'd24;
    localparam logic [POS_W:0] RR_INFO_BYTES = 6'd4;
    localparam logic [POS_W-1:0] HDR_LAST_POS = 5'd3;

    // record queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one result record
    typedef struct packed {
        logic [ID_W-1:0]     field_id;
        logic [VALUE_W-1:0]  field_value;
        logic [BLOCK_W-1:0]  block_index;
        logic [STATUS_W-1:0] status_code;
        logic                end_of_packet;
    } t_rec;

    // up to two records produced by one byte
    typedef struct packed {
        logic [1:0] num;
        t_rec       rec0;
        t_rec       rec1;
    } t_rec_pair;

endpackage

### rtl/rpfp_byte_if.sv
// rpfp_byte_if: packet byte request channel
// depends on rpfp_pkg

interface rpfp_byte_if;
    import rpfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

### rtl/rpfp_rec_if.sv
// rpfp_rec_if: parsed field record request channel
// depends on rpfp_pkg

interface rpfp_rec_if;
    import rpfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     field_id;
    logic [VALUE_W-1:0]  field_value;
    logic [BLOCK_W-1:0]  block_index;
    logic [STATUS_W-1:0] status_code;
    logic                end_of_packet;

    modport source (output valid, output field_id, output field_value, output block_index,
                    output status_code, output end_of_packet, input ready);
    modport sink   (input valid, input field_id, input field_value, input block_index,
                    input status_code, input end_of_packet, output ready);
endinterface

### rtl/rtcp_packet_field_parser_unit.sv
// rtcp_packet_field_parser_unit: top level of the rtcp packet field parser
// depends on rpfp_pkg, rpfp_byte_if, rpfp_rec_if, rpfp_parse and rpfp_rec_queue

// Takes one RTCP packet as a byte stream and emits one record per completed field
// (header, SSRC, sender info, report block fields with their block number), then a
// status record with end_of_packet set on the byte flagged last_byte. The single-record
// output port sets the rate: a byte that yields two records (header bytes 0 and 1, or
// a final byte that also completes a field) has them leave one at a time. The input waits
// whenever the four-entry record queue holds more than two records, so even with an
// always-ready sink a header of four or more bytes stalls the input; body bytes yield
// at most one record each and are taken every cycle once the queue has drained. A
// record is registered in the input byte register and then in the record queue before
// it is presented, and it can leave as soon as the sink is ready.

module rtcp_packet_field_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpfp_byte_if.sink   i_byte,
    rpfp_rec_if.source  o_rec
);
    import rpfp_pkg::*;

    t_rec_pair w_push;
    logic      w_room;

    // byte decode
    rpfp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // record queue toward the output
    rpfp_rec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_rec   (o_rec)
    );

endmodule

### rtl/rpfp_parse.sv
// rpfp_parse: input byte register, rtcp parse state and per-byte field decode
// depends on rpfp_pkg and rpfp_byte_if

module rpfp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rpfp_byte_if.sink          i_byte,
    input  logic               i_room,
    output rpfp_pkg::t_rec_pair o_push
);
    import rpfp_pkg::*;

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // parse state
    logic [PH_W-1:0]     r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [BLOCK_W-1:0]  r_rc, n_rc;
    logic [BLOCK_W-1:0]  r_blk, n_blk;
    logic [BYTE_W-1:0]   r_kind, n_kind;
    logic [STATUS_W-1:0] r_err, n_err;

    logic        w_take;
    logic [1:0]  w_nf;
    t_rec        w_f0, w_f1, w_st;
    logic        w_short;
    logic [POS_W:0] w_pos_inc;
    logic [POS_W:0] w_info_len;
    logic [BLOCK_W:0] w_blk_inc;

    assign w_take       = r_in_vld && i_room;
    assign i_byte.ready = !r_in_vld || w_take;

    // input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.byte_value;
            r_last <= i_byte.last_byte;
        end
    end

    assign w_pos_inc  = {1'b0, r_pos} + 6'd1;
    assign w_info_len = (r_kind == KIND_SR) ? SR_INFO_BYTES : RR_INFO_BYTES;
    assign w_blk_inc  = {1'b0, r_blk} + 6'd1;

    // per-byte decode and next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_acc   = {r_acc[VALUE_W-BYTE_W-1:0], r_byte};
        n_rc    = r_rc;
        n_blk   = r_blk;
        n_kind  = r_kind;
        n_err   = r_err;
        w_short = 1'b0;
        w_nf    = 2'd0;
        w_f0    = '0;
        w_f1    = '0;
        w_st    = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos == 5'd0) begin
                    n_rc = r_byte[BLOCK_W-1:0];
                    if (!r_last) begin
                        w_nf = 2'd2;
                        w_f0.field_id    = ID_VERSION;
                        w_f0.field_value = {30'd0, r_byte[7:6]};
                        w_f1.field_id    = ID_PADDING;
                        w_f1.field_value = {31'd0, r_byte[5]};
                    end
                end else if (r_pos == 5'd1) begin
                    n_kind = r_byte;
                    if (!r_last) begin
                        w_nf = 2'd2;
                        w_f0.field_id    = ID_COUNT;
                        w_f0.field_value = {27'd0, r_rc};
                        w_f1.field_id    = ID_TYPE;
                        w_f1.field_value = {24'd0, r_byte};
                    end
                end
                if (r_pos < HDR_LAST_POS) begin
                    n_pos   = w_pos_inc[POS_W-1:0];
                    w_short = 1'b1;
                end else begin
                    w_nf = 2'd1;
                    w_f0.field_id    = ID_LENGTH;
                    w_f0.field_value = {16'd0, n_acc[15:0]};
                    n_pos = '0;
                    n_blk = '0;
                    if (r_kind == KIND_SR || r_kind == KIND_RR) begin
                        n_phase = PH_INFO;
                    end else begin
                        n_phase = PH_SKIP;
                        if (r_kind < KIND_SDES || r_kind > KIND_APP) begin
                            n_err = ST_UNKNOWN;
                        end
                    end
                end
            end
            PH_INFO: begin
                // one word of ssrc or sender info completes every fourth byte
                if (r_pos[1:0] == 2'd3) begin
                    w_nf = 2'd1;
                    w_f0.field_id    = ID_SSRC + {2'd0, r_pos[4:2]};
                    w_f0.field_value = n_acc;
                end
                if (w_pos_inc >= w_info_len) begin
                    n_pos   = '0;
                    n_blk   = '0;
                    n_phase = (r_rc == '0) ? PH_SKIP : PH_BLOCK;
                end else begin
                    n_pos = w_pos_inc[POS_W-1:0];
                end
            end
            PH_BLOCK: begin
                // report block field ends
                w_f0.block_index = r_blk;
                w_f0.field_value = n_acc;
                case (r_pos)
                    5'd3: begin
                        w_nf = 2'd1;
                        w_f0.field_id = ID_SRC_SSRC;
                    end
                    5'd4: begin
                        w_nf = 2'd1;
                        w_f0.field_id    = ID_FRAC;
                        w_f0.field_value = {24'd0, n_acc[7:0]};
                    end
                    5'd7: begin
                        w_nf = 2'd1;
                        w_f0.field_id    = ID_CUM_LOST;
                        w_f0.field_value = {8'd0, n_acc[23:0]};
                    end
                    5'd11: begin
                        w_nf = 2'd1;
                        w_f0.field_id = ID_EXT_SEQ;
                    end
                    5'd15: begin
                        w_nf = 2'd1;
                        w_f0.field_id = ID_JITTER;
                    end
                    5'd19: begin
                        w_nf = 2'd1;
                        w_f0.field_id = ID_LSR;
                    end
                    5'd23: begin
                        w_nf = 2'd1;
                        w_f0.field_id = ID_DLSR;
                    end
                    default: begin
                        w_nf = 2'd0;
                    end
                endcase
                if (w_pos_inc >= BLOCK_BYTES) begin
                    n_pos = '0;
                    n_blk = w_blk_inc[BLOCK_W-1:0];
                    if (w_blk_inc >= {1'b0, r_rc}) begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_pos = w_pos_inc[POS_W-1:0];
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // status record on the final byte, then back to the header phase
        w_st.field_id      = ID_STATUS;
        w_st.end_of_packet = 1'b1;
        if (w_short) begin
            w_st.status_code = ST_SHORT;
        end else if (n_err != ST_OK) begin
            w_st.status_code = n_err;
        end else if (n_phase == PH_INFO || n_phase == PH_BLOCK) begin
            w_st.status_code = ST_TRUNC;
        end else begin
            w_st.status_code = ST_OK;
        end
        if (r_last) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_acc   = '0;
            n_rc    = '0;
            n_blk   = '0;
            n_kind  = '0;
            n_err   = ST_OK;
        end
    end

    // record pair toward the queue
    always_comb begin
        o_push.num  = w_take ? (w_nf + {1'b0, r_last}) : 2'd0;
        o_push.rec0 = (w_nf != 2'd0) ? w_f0 : w_st;
        o_push.rec1 = (w_nf == 2'd2) ? w_f1 : w_st;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_acc   <= '0;
            r_rc    <= '0;
            r_blk   <= '0;
            r_kind  <= '0;
            r_err   <= ST_OK;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_rc    <= n_rc;
            r_blk   <= n_blk;
            r_kind  <= n_kind;
            r_err   <= n_err;
        end
    end

`ifndef NO_ASSERTIONS
    // a consumed final byte leaves the parser at the start of a header
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_last) |=> (r_phase == PH_HEADER && r_pos == '0 && r_err == ST_OK))
        else $error("parse state not cleared after final byte");

    // header bytes are counted only up to the length field
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos <= HDR_LAST_POS))
        else $error("header byte position out of range");

    // block parsing stays below the report count
    a_block_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BLOCK) |-> (r_blk < r_rc))
        else $error("report block index beyond count");

    // records leave only for a consumed byte, and a final byte always leaves one
    a_push_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num != 2'd0) == (w_take && (r_last || w_nf != 2'd0)))
        else $error("record push does not match consumed byte");
`endif

endmodule

### rtl/rpfp_rec_queue.sv
// rpfp_rec_queue: small record queue, two writes and one read per cycle
// depends on rpfp_pkg and rpfp_rec_if

module rpfp_rec_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpfp_pkg::t_rec_pair i_push,
    output logic                o_room,
    rpfp_rec_if.source          o_rec
);
    import rpfp_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_pop;
    logic [QPTR_W-1:0] w_wr1;
    t_rec              w_head;

    assign w_pop  = (r_cnt != '0) && o_rec.ready;
    assign w_wr1  = r_wr + QPTR_W'(1);
    // room for a full pair regardless of the read side
    assign o_room = r_cnt <= QCNT_W'(QUEUE_DEPTH - 2);

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[w_wr1] <= i_push.rec1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(i_push.num);
            r_rd  <= r_rd + QPTR_W'(w_pop);
            r_cnt <= r_cnt + QCNT_W'(i_push.num) - QCNT_W'(w_pop);
        end
    end

    // head of queue drives the output channel
    assign w_head              = r_mem[r_rd];
    assign o_rec.valid         = r_cnt != '0;
    assign o_rec.field_id      = w_head.field_id;
    assign o_rec.field_value   = w_head.field_value;
    assign o_rec.block_index   = w_head.block_index;
    assign o_rec.status_code   = w_head.status_code;
    assign o_rec.end_of_packet = w_head.end_of_packet;

`ifndef NO_ASSERTIONS
    // the fill count never exceeds the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("record queue overflow");

    // writes arrive only when a full pair fits
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("record pushed without room");

    // pointer distance matches the fill count
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_cnt[QPTR_W-1:0])
        else $error("record queue pointers disagree with count");
`endif

endmodule
